### rtl/swm_pkg.sv
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [CFG_W-1:0]           cfg_t;

    // packed so that window_max lands in the low bits of the output tdata
    typedef struct packed {
        pos_t    window_end;
        sample_t window_max;
    } result_t;

endpackage

### rtl/sliding_window_maximum_core.sv
// sliding window maximum over a stream of signed 32-bit samples
// s_axis: one sample per transaction, tdata = sample, tuser = sequence_start
//   (sequence_start clears the window before its sample is taken)
// m_axis: tdata[31:0] = window max, tdata[63:32] = position of the newest
//   sample in its sequence; one result per sample once window_size samples
//   of the sequence have arrived, none before
// cfg: write window_size (0 acts as 1, above WINDOW_MAX saturates) while idle;
//   a larger size set mid-sequence does not bring back samples already aged out
// a taken sample's result is registered and appears on m_axis the next
// cycle; one sample per clock is sustained while m_axis is not stalling, set
// by the row of running-max cells, each a single compare against its neighbor
// a held result does not stop input as long as m_axis takes it in the same
// cycle; while m_axis stalls with a result waiting, s_axis_tready is low
// reset clears the fill count, the live-sample count, the position counter
// and the output valid, and sets window_size to 3; no clearing pass is needed
module sliding_window_maximum_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // sample
    input  logic        s_axis_tuser,  // sequence_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // window_max, window_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data       // window_size
);
    import swm_pkg::*;

    localparam int CELLS = WINDOW_MAX - 1;
    localparam int IW    = $clog2(WINDOW_MAX);
    localparam int KW    = ($clog2(WINDOW_MAX + 1) > CFG_W) ? $clog2(WINDOW_MAX + 1) : CFG_W;

    typedef logic [KW-1:0] count_t;

    cfg_t    window_size_reg;
    count_t  fill_reg;
    count_t  fill_next;
    count_t  live_reg;
    count_t  live_next;
    pos_t    seen_reg;
    pos_t    seen_next;

    count_t  ws_ext;
    count_t  k_eff;
    count_t  fill_base;
    count_t  live_base;
    count_t  live_mid;
    pos_t    pos;
    logic    accept;
    logic    emit;
    logic    room;
    sample_t sample;
    sample_t tap;
    result_t result;
    result_t out_result;
    logic [IW-1:0] sel;

    sample_t chain [CELLS+1];

    assign cfg_ready     = 1'b1;
    assign sample        = sample_t'(s_axis_tdata);
    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ws_ext = KW'(window_size_reg);
        if (ws_ext == '0)
        begin
            k_eff = KW'(1);
        end
        else if (ws_ext > KW'(WINDOW_MAX))
        begin
            k_eff = KW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = ws_ext;
        end
    end

    always_comb
    begin
        fill_base = s_axis_tuser ? '0 : fill_reg;
        live_base = s_axis_tuser ? '0 : live_reg;
        pos       = s_axis_tuser ? '0 : seen_reg;
        seen_next = pos + POS_W'(1);
        if (fill_base == KW'(WINDOW_MAX))
        begin
            fill_next = fill_base;
        end
        else
        begin
            fill_next = fill_base + KW'(1);
        end
        // older samples that left the window stay out even if the window grows
        if (live_base < k_eff - KW'(1))
        begin
            live_mid = live_base;
        end
        else
        begin
            live_mid = k_eff - KW'(1);
        end
        live_next = live_mid + KW'(1);
        emit = (fill_next >= k_eff);
    end

    // cell i holds the max of the newest i+1 samples
    assign chain[0] = sample;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        swm_cell u_cell (
            .clk      (clk),
            .shift_en (accept),
            .sample   (sample),
            .prev_max (chain[i]),
            .run_max  (chain[i+1])
        );
    end

    // old max of the newest still-live samples, combined with the incoming one
    assign sel = IW'(live_mid);
    assign tap = chain[sel];

    always_comb
    begin
        result.window_end = pos;
        if (live_mid == '0 || sample > tap)
        begin
            result.window_max = sample;
        end
        else
        begin
            result.window_max = tap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= CFG_W'(3);
            fill_reg        <= '0;
            live_reg        <= '0;
            seen_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_size_reg <= cfg_data;
            end
            if (accept)
            begin
                fill_reg <= fill_next;
                live_reg <= live_next;
                seen_reg <= seen_next;
            end
        end
    end

    swm_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && emit),
        .load_data (result),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = out_result;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= KW'(WINDOW_MAX))
        else $error("fill count beyond window depth");

    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_end_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (m_axis_tvalid && m_axis_tdata[63:32] == seen_reg - POS_W'(1)))
        else $error("result position does not match sample count");

endmodule

### rtl/swm_cell.sv
module swm_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  swm_pkg::sample_t sample,
    input  swm_pkg::sample_t prev_max,
    output swm_pkg::sample_t run_max
);
    import swm_pkg::*;

    sample_t run_max_reg;
    sample_t run_max_next;

    // running max over one more sample than the neighbor held
    always_comb
    begin
        if (sample > prev_max)
        begin
            run_max_next = sample;
        end
        else
        begin
            run_max_next = prev_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            run_max_reg <= run_max_next;
        end
    end

    assign run_max = run_max_reg;

endmodule

### rtl/swm_obuf.sv
module swm_obuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  swm_pkg::result_t load_data,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output swm_pkg::result_t out_data
);
    import swm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // room for a new result when empty or when the held one leaves this cycle
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
